// ----- hw/rtl/gn2_pkg.sv -----
// gn2_pkg: widths, hash constants and the quarter-wave sine table of the
// gradient noise unit. Depends on nothing; imported by the interfaces and
// the top level.
package gn2_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int SINE_TABLE_BITS = 10;

  localparam int COORD_W  = 32;
  localparam int CELL_W   = COORD_W - FRAC_BITS;
  localparam int OUT_W    = 16;
  localparam int SINE_N   = 1 << SINE_TABLE_BITS;
  localparam int PHASE_W  = SINE_TABLE_BITS + 2;
  localparam int IDX_W    = SINE_TABLE_BITS + 1;
  localparam int TAB_W    = 15;
  localparam int GRAD_W   = 16;
  localparam int DOT_FRAC = 20;
  localparam int DOT_SH   = FRAC_BITS + 14 - DOT_FRAC;
  localparam int FINAL_SH = DOT_FRAC - 14;
  localparam int OFS_W    = FRAC_BITS + 1;
  localparam int PROD_W   = OFS_W + GRAD_W;
  localparam int SUM_W    = PROD_W + 1;
  localparam int DOT_W    = SUM_W - DOT_SH;
  localparam int WGT_W    = FRAC_BITS + 1;
  localparam int MIX_W    = DOT_W + 2 + WGT_W;
  localparam int CFG_AW   = 3;

  localparam logic [31:0] HASH_MUL_A = 32'd3284157443;
  localparam logic [31:0] HASH_MUL_B = 32'd1911520717;
  localparam logic [31:0] HASH_MUL_C = 32'd2048419325;
  localparam logic [63:0] PI_Q30     = 64'd3373259426;

  // register word addresses
  localparam logic [CFG_AW-3:0] REG_NOISE_SEED = '0;

  typedef logic [TAB_W-1:0] sine_tab_t [SINE_N+1];

  // table lookup for one phase: entry index and sign
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             neg;
  } sine_sel_t;

  // sin(pi/2*k/N) by a truncated taylor series in q30, rounded to q1.14
  function automatic sine_tab_t build_sine();
    sine_tab_t   tab;
    logic [63:0] th, th2, term, pos, neg, s, e;
    for (int k = 0; k <= SINE_N; k++) begin
      th   = (PI_Q30 * 64'(k)) >> (SINE_TABLE_BITS + 1);
      th2  = (th * th) >> 30;
      term = th;
      pos  = th;
      neg  = '0;
      for (int n = 1; n <= 10; n++) begin
        term = ((term * th2) >> 30) / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) neg = neg + term;
        else pos = pos + term;
      end
      s = (pos >= neg) ? pos - neg : 64'd0;
      e = (s + 64'd32768) >> 16;
      if (e > 64'd16384) e = 64'd16384;
      tab[k] = e[TAB_W-1:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine();

  // quadrant folding onto the quarter-wave table
  function automatic sine_sel_t sine_select(input logic [PHASE_W-1:0] p);
    sine_sel_t                    sel;
    logic [1:0]                   q;
    logic [SINE_TABLE_BITS-1:0]   r;
    q = p[PHASE_W-1:SINE_TABLE_BITS];
    r = p[SINE_TABLE_BITS-1:0];
    if (q[0]) sel.idx = IDX_W'(SINE_N) - {1'b0, r};
    else sel.idx = {1'b0, r};
    sel.neg = q[1];
    return sel;
  endfunction

  function automatic logic [31:0] rotl16(input logic [31:0] v);
    return {v[15:0], v[31:16]};
  endfunction

endpackage

// ----- hw/rtl/gn2_point_if.sv -----
// gn2_point_if: request channel carrying one point in unsigned fixed point.
// Depends on gn2_pkg.
interface gn2_point_if
  import gn2_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] point_x;
  logic [COORD_W-1:0] point_y;

  modport source (output valid, point_x, point_y, input ready);
  modport sink   (input valid, point_x, point_y, output ready);
endinterface

// ----- hw/rtl/gn2_noise_if.sv -----
// gn2_noise_if: result channel carrying one signed q2.14 noise value.
// Depends on gn2_pkg.
interface gn2_noise_if
  import gn2_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] noise_value;

  modport source (output valid, noise_value, input ready);
  modport sink   (input valid, noise_value, output ready);
endinterface

// ----- hw/rtl/gradient_noise_2d_unit.sv -----
// gradient_noise_2d_unit: ten-stage pipeline for 2d gradient noise.
// Depends on gn2_pkg, gn2_point_if and gn2_noise_if.
//
//   channel  | dir | handshake       | payload
//   in_if    | in  | valid / ready   | point_x, point_y (q16.16)
//   out_if   | out | valid / ready   | noise_value (q2.14)
//   cfg_*    | in  | apb, pready = 1 | noise_seed at byte 0
//
// one request per cycle unless a stalled result has filled the pipeline; the
// result leaves from the stage 10 output register. the three chained hash
// multipliers and the lerp multipliers set the stage count. each stage holds
// only while the one after it is full and stalled, so bubbles close up and a
// waiting result stops new requests only once all ten stages are full.
// synchronous reset clears the valid bits and the seed.
module gradient_noise_2d_unit
  import gn2_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  gn2_point_if.sink            in_if,
  gn2_noise_if.source          out_if,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [CFG_AW-1:0]    cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  localparam int NST = 10;
  localparam logic signed [SUM_W-1:0] DOT_HALF   = SUM_W'(1) << (DOT_SH - 1);
  localparam logic signed [DOT_W:0]   FINAL_HALF = (DOT_W + 1)'(1) << (FINAL_SH - 1);
  localparam logic signed [OFS_W-1:0] ONE        = OFS_W'(1) << FRAC_BITS;
  localparam logic [FRAC_BITS+1:0]    THREE      = (FRAC_BITS + 2)'(3) << FRAC_BITS;

  // configuration register
  logic [31:0] seed_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[CFG_AW-1:2] == REG_NOISE_SEED) ? seed_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite
                 && cfg_paddr[CFG_AW-1:2] == REG_NOISE_SEED) begin
      seed_r <= cfg_pwdata;
    end
  end

  // stage valids and enables
  logic [NST:1] v_r;
  logic [NST:1] en;

  always_comb begin
    en[NST] = !v_r[NST] || out_if.ready;
    for (int k = NST - 1; k >= 1; k--) en[k] = !v_r[k] || en[k+1];
  end

  assign in_if.ready = en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) v_r[1] <= in_if.valid;
      for (int k = 2; k <= NST; k++) begin
        if (en[k]) v_r[k] <= v_r[k-1];
      end
    end
  end

  // stage 1: first hash product, weight squares
  logic [31:0]          ax0_r;
  logic [CELL_W-1:0]    y0_r;
  logic [FRAC_BITS-1:0] fx_r, fy_r, w2x_r, w2y_r;
  logic [2*FRAC_BITS-1:0] sqx, sqy;

  assign sqx = in_if.point_x[FRAC_BITS-1:0] * in_if.point_x[FRAC_BITS-1:0];
  assign sqy = in_if.point_y[FRAC_BITS-1:0] * in_if.point_y[FRAC_BITS-1:0];

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ax0_r <= 32'(32'(in_if.point_x[COORD_W-1:FRAC_BITS]) * HASH_MUL_A);
      y0_r  <= in_if.point_y[COORD_W-1:FRAC_BITS];
      fx_r  <= in_if.point_x[FRAC_BITS-1:0];
      fy_r  <= in_if.point_y[FRAC_BITS-1:0];
      w2x_r <= sqx[2*FRAC_BITS-1:FRAC_BITS];
      w2y_r <= sqy[2*FRAC_BITS-1:FRAC_BITS];
    end
  end

  // stage 2: second hash product per corner, smoothstep weights
  // corner order: (x0,y0) (x1,y0) (x0,y1) (x1,y1); x1 hash is ax0 + mul_a
  logic [31:0]          ax1, cy0, cy1;
  logic [31:0]          b_r [4];
  logic [31:0]          ax0_2_r, ax1_2_r;
  logic [FRAC_BITS-1:0] fx_2_r, fy_2_r;
  logic [WGT_W-1:0]     sx_2_r, sy_2_r;
  logic [2*FRAC_BITS+1:0] smx, smy;

  assign ax1 = ax0_r + HASH_MUL_A;
  assign cy0 = 32'(y0_r);
  assign cy1 = 32'(y0_r) + 32'd1;
  assign smx = w2x_r * (THREE - {1'b0, fx_r, 1'b0});
  assign smy = w2y_r * (THREE - {1'b0, fy_r, 1'b0});

  always_ff @(posedge clk) begin
    if (en[2]) begin
      b_r[0]  <= 32'((cy0 ^ rotl16(ax0_r)) * HASH_MUL_B);
      b_r[1]  <= 32'((cy0 ^ rotl16(ax1)) * HASH_MUL_B);
      b_r[2]  <= 32'((cy1 ^ rotl16(ax0_r)) * HASH_MUL_B);
      b_r[3]  <= 32'((cy1 ^ rotl16(ax1)) * HASH_MUL_B);
      ax0_2_r <= ax0_r;
      ax1_2_r <= ax1;
      fx_2_r  <= fx_r;
      fy_2_r  <= fy_r;
      sx_2_r  <= smx[FRAC_BITS+WGT_W-1:FRAC_BITS];
      sy_2_r  <= smy[FRAC_BITS+WGT_W-1:FRAC_BITS];
    end
  end

  // stage 3: final hash product, seed mix, angle phase
  logic [31:0]          hx [4];
  logic [PHASE_W-1:0]   ph_r [4];
  logic [FRAC_BITS-1:0] fx_3_r, fy_3_r;
  logic [WGT_W-1:0]     sx_3_r, sy_3_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      hx[i] = 32'((((i % 2) == 1 ? ax1_2_r : ax0_2_r) ^ rotl16(b_r[i])) * HASH_MUL_C)
              ^ seed_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int i = 0; i < 4; i++) ph_r[i] <= hx[i][31 -: PHASE_W];
      fx_3_r <= fx_2_r;
      fy_3_r <= fy_2_r;
      sx_3_r <= sx_2_r;
      sy_3_r <= sy_2_r;
    end
  end

  // stage 4: sine table reads for cos and sin of each corner
  sine_sel_t            selc [4];
  sine_sel_t            sels [4];
  logic [TAB_W-1:0]     tc_r [4];
  logic [TAB_W-1:0]     ts_r [4];
  logic [3:0]           nc_r, ns_r;
  logic [FRAC_BITS-1:0] fx_4_r, fy_4_r;
  logic [WGT_W-1:0]     sx_4_r, sy_4_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      selc[i] = sine_select(ph_r[i] + PHASE_W'(SINE_N));
      sels[i] = sine_select(ph_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int i = 0; i < 4; i++) begin
        tc_r[i] <= SINE_TAB[selc[i].idx];
        ts_r[i] <= SINE_TAB[sels[i].idx];
        nc_r[i] <= selc[i].neg;
        ns_r[i] <= sels[i].neg;
      end
      fx_4_r <= fx_3_r;
      fy_4_r <= fy_3_r;
      sx_4_r <= sx_3_r;
      sy_4_r <= sy_3_r;
    end
  end

  // stage 5: gradient times offset
  logic signed [GRAD_W-1:0] gx [4];
  logic signed [GRAD_W-1:0] gy [4];
  logic signed [OFS_W-1:0]  dx0, dx1, dy0, dy1;
  logic signed [PROD_W-1:0] px_r [4];
  logic signed [PROD_W-1:0] py_r [4];
  logic [WGT_W-1:0]         sx_5_r, sy_5_r;

  assign dx0 = $signed({1'b0, fx_4_r});
  assign dx1 = $signed({1'b0, fx_4_r}) - ONE;
  assign dy0 = $signed({1'b0, fy_4_r});
  assign dy1 = $signed({1'b0, fy_4_r}) - ONE;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      gx[i] = nc_r[i] ? -$signed({1'b0, tc_r[i]}) : $signed({1'b0, tc_r[i]});
      gy[i] = ns_r[i] ? -$signed({1'b0, ts_r[i]}) : $signed({1'b0, ts_r[i]});
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int i = 0; i < 4; i++) begin
        px_r[i] <= ((i % 2) == 1 ? dx1 : dx0) * gx[i];
        py_r[i] <= ((i / 2) == 1 ? dy1 : dy0) * gy[i];
      end
      sx_5_r <= sx_4_r;
      sy_5_r <= sy_4_r;
    end
  end

  // stage 6: dot sums rounded to 20 fraction bits
  logic signed [SUM_W-1:0] dsum [4];
  logic signed [DOT_W-1:0] dot_r [4];
  logic [WGT_W-1:0]        sx_6_r, sy_6_r;

  always_comb begin
    for (int i = 0; i < 4; i++) dsum[i] = (px_r[i] + py_r[i] + DOT_HALF) >>> DOT_SH;
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int i = 0; i < 4; i++) dot_r[i] <= dsum[i][DOT_W-1:0];
      sx_6_r <= sx_5_r;
      sy_6_r <= sy_5_r;
    end
  end

  // stage 7: x blend products
  logic signed [MIX_W-1:0] mt_r, mb_r;
  logic signed [DOT_W-1:0] d0_r, d2_r;
  logic [WGT_W-1:0]        sy_7_r;
  logic signed [DOT_W:0]   dift, difb;

  assign dift = $signed((DOT_W + 1)'(dot_r[1])) - $signed((DOT_W + 1)'(dot_r[0]));
  assign difb = $signed((DOT_W + 1)'(dot_r[3])) - $signed((DOT_W + 1)'(dot_r[2]));

  always_ff @(posedge clk) begin
    if (en[7]) begin
      mt_r   <= dift * $signed({1'b0, sx_6_r});
      mb_r   <= difb * $signed({1'b0, sx_6_r});
      d0_r   <= dot_r[0];
      d2_r   <= dot_r[2];
      sy_7_r <= sy_6_r;
    end
  end

  // stage 8: x blend sums
  logic signed [MIX_W-1:0] mts, mbs;
  logic signed [DOT_W:0]   topw, botw;
  logic signed [DOT_W-1:0] top_r, bot_r;
  logic [WGT_W-1:0]        sy_8_r;

  assign mts  = mt_r >>> FRAC_BITS;
  assign mbs  = mb_r >>> FRAC_BITS;
  assign topw = $signed((DOT_W + 1)'(d0_r)) + mts[DOT_W:0];
  assign botw = $signed((DOT_W + 1)'(d2_r)) + mbs[DOT_W:0];

  always_ff @(posedge clk) begin
    if (en[8]) begin
      top_r  <= topw[DOT_W-1:0];
      bot_r  <= botw[DOT_W-1:0];
      sy_8_r <= sy_7_r;
    end
  end

  // stage 9: y blend product
  logic signed [DOT_W:0]   difv;
  logic signed [MIX_W-1:0] mv_r;
  logic signed [DOT_W-1:0] top_9_r;

  assign difv = $signed((DOT_W + 1)'(bot_r)) - $signed((DOT_W + 1)'(top_r));

  always_ff @(posedge clk) begin
    if (en[9]) begin
      mv_r    <= difv * $signed({1'b0, sy_8_r});
      top_9_r <= top_r;
    end
  end

  // stage 10: y blend, round to q2.14, saturate into the output register
  logic signed [MIX_W-1:0] mvs;
  logic signed [DOT_W:0]   rsum, rnd;
  logic signed [OUT_W-1:0] res;
  logic signed [OUT_W-1:0] out_r;

  assign mvs  = mv_r >>> FRAC_BITS;
  assign rsum = $signed((DOT_W + 1)'(top_9_r)) + mvs[DOT_W:0];
  assign rnd  = (rsum + FINAL_HALF) >>> FINAL_SH;

  always_comb begin
    if (rnd > $signed((DOT_W + 1)'(32767))) res = 16'sd32767;
    else if (rnd < -$signed((DOT_W + 1)'(32768))) res = -16'sd32768;
    else res = rnd[OUT_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[10]) out_r <= res;
  end

  assign out_if.valid       = v_r[NST];
  assign out_if.noise_value = out_r;

endmodule
